[hdl/gial_pkg.sv]
package gial_pkg;

    localparam int WORD_W    = 32;
    localparam int DWORD_W   = 64;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    // operand_kind bit positions
    localparam int KIND_A = 2;
    localparam int KIND_B = 1;
    localparam int KIND_C = 0;

    // modifier bit positions
    localparam int MOD_M0 = 0;
    localparam int MOD_M1 = 1;

    typedef enum logic [1:0] {
        OP_MAD = 2'd0,
        OP_LOP = 2'd1,
        OP_SHF = 2'd2,
        OP_LEA = 2'd3
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [4:0]  lane;
        logic [7:0]  dest_reg;
        logic [31:0] src_a;
        logic [31:0] src_b;
        logic [31:0] src_c;
        logic [2:0]  kind;
        logic [7:0]  lut;
        logic [1:0]  modifier;
        logic [2:0]  pred_dest;
        logic [2:0]  pred_src;
    } t_item;

    typedef struct packed {
        logic [31:0] lo;
        logic [31:0] hi;
        logic        carry;
        logic        err;
    } t_result;

endpackage

[hdl/gpu_integer_alu_lane.sv]
// A transaction passes through r_q, r_x and r_w into the output queue. Input is held
// off (o_stall) while one still reads c and c+1, or while the output queue could fill;
// the register file has one write port and two read ports, and an instruction reads
// up to four words. Reset: synchronous, active low; after reset a clearing pass zeroes
// every entry of the register and predicate files with o_stall high.
module gpu_integer_alu_lane #(
    parameter int THREADS = 32,
    parameter int REGS    = 256,
    parameter int PREDS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [4:0]  i_lane,
    input  logic [7:0]  i_dest_reg,
    input  logic [31:0] i_src_a,
    input  logic [31:0] i_src_b,
    input  logic [31:0] i_src_c,
    input  logic [2:0]  i_operand_kind,
    input  logic [7:0]  i_lut_or_shift,
    input  logic [1:0]  i_modifier,
    input  logic [2:0]  i_pred_dest,
    input  logic [2:0]  i_pred_src,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_low,
    output logic [31:0] o_result_high,
    output logic        o_carry_out,
    output logic        o_index_error
);

    localparam int RDEPTH = THREADS * REGS;
    localparam int AW     = $clog2(RDEPTH);
    localparam int PDEPTH = THREADS * PREDS;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;
    localparam int CLR_N  = (RDEPTH > PDEPTH) ? RDEPTH : PDEPTH;
    localparam int CW     = $clog2(CLR_N);

    typedef struct packed {
        logic          we;
        logic [AW-1:0] addr;
        logic [31:0]   data;
    } t_wr;

    typedef struct packed {
        logic           we;
        logic [PAW-1:0] addr;
        logic           data;
    } t_pwr;

    typedef struct packed {
        gial_pkg::t_op  op;
        logic           m0;
        logic [31:0]    lo_x;
        logic           carry;
        logic           err;
        logic [63:0]    c64;
        logic           we_lo;
        logic           we_hi;
        logic           we_p;
        logic [AW-1:0]  a_lo;
        logic [AW-1:0]  a_hi;
        logic [PAW-1:0] a_p;
    } t_wst;

    function automatic logic lane_ok(input logic [4:0] lane);
        return int'(lane) < THREADS;
    endfunction

    function automatic logic reg_ok(input logic [4:0] lane, input logic [32:0] idx);
        return lane_ok(lane) && (idx < 33'(REGS));
    endfunction

    function automatic logic [AW-1:0] reg_addr(input logic [4:0] lane, input logic [7:0] idx);
        return AW'(lane) * AW'(REGS) + AW'(idx);
    endfunction

    function automatic logic [PAW-1:0] pred_addr(input logic [4:0] lane,
                                                 input logic [2:0] idx);
        return PAW'(lane) * PAW'(PREDS) + PAW'(idx);
    endfunction

    function automatic logic [31:0] fwd(input logic [AW-1:0] addr, input logic [31:0] raw,
                                        input t_wr cur, input t_wr h1, input t_wr h2);
        logic [31:0] v;
        v = raw;
        if (cur.we && cur.addr == addr) begin
            v = cur.data;
        end else if (h1.we && h1.addr == addr) begin
            v = h1.data;
        end else if (h2.we && h2.addr == addr) begin
            v = h2.data;
        end
        return v;
    endfunction

    function automatic logic pfwd(input logic [PAW-1:0] addr, input logic raw,
                                  input t_pwr cur, input t_pwr h1, input t_pwr h2);
        logic v;
        v = raw;
        if (cur.we && cur.addr == addr) begin
            v = cur.data;
        end else if (h1.we && h1.addr == addr) begin
            v = h1.data;
        end else if (h2.we && h2.addr == addr) begin
            v = h2.data;
        end
        return v;
    endfunction

    // control
    logic                 r_clr;
    logic [CW-1:0]        r_ccnt;
    logic                 r_v1, r_vx, r_vw;
    gial_pkg::t_item      r_q, r_x, w_in;
    logic [31:0]          r_da, r_db;
    logic                 r_pd;
    t_wst                 r_w, n_w;
    logic [63:0]          r_prod, w_prod;
    logic                 r_hp_we;
    logic [AW-1:0]        r_hp_a;
    logic [31:0]          r_hp_d;
    t_wr                  w_cur, r_h1, r_h2;
    t_pwr                 w_pcur, r_ph1, r_ph2;
    logic                 w_acc, w_pop;

    // memories
    logic [1:0][AW-1:0]   w_raddr;
    logic [1:0][31:0]     w_rdata;
    logic [0:0][PAW-1:0]  w_praddr;
    logic [0:0][0:0]      w_prdata;

    // output queue
    gial_pkg::t_result    r_oq [gial_pkg::OUT_DEPTH];
    logic [gial_pkg::OUT_PTR_W-1:0] r_wp, r_rp;
    logic [gial_pkg::OUT_CNT_W-1:0] r_ocnt;
    gial_pkg::t_result    w_res;

    // execute-stage signals
    logic                 w_ia, w_ib, w_ic, w_m0, w_m1;
    logic                 w_ok_a, w_ok_b, w_ok_c, w_ok_c1, w_ok_rd, w_ok_rd1, w_ok_ps, w_ok_pd;
    logic [31:0]          w_a, w_b, w_c, w_c1;
    logic                 w_p;
    logic [63:0]          w_pair, w_shf, w_lea_v;
    logic [32:0]          w_sum33;
    logic [31:0]          w_lop;
    logic [2:0]           w_m;
    logic [5:0]           w_hsh;
    logic [8:0]           w_rd1;
    logic [32:0]          w_c1_idx;
    logic [63:0]          w_mad;

    assign w_in = '{op: gial_pkg::t_op'(i_op), lane: i_lane, dest_reg: i_dest_reg,
                    src_a: i_src_a, src_b: i_src_b, src_c: i_src_c, kind: i_operand_kind,
                    lut: i_lut_or_shift, modifier: i_modifier, pred_dest: i_pred_dest,
                    pred_src: i_pred_src};

    assign o_stall = r_clr || r_v1 ||
        ((r_ocnt + gial_pkg::OUT_CNT_W'(r_vx) + gial_pkg::OUT_CNT_W'(r_vw))
         >= gial_pkg::OUT_CNT_W'(gial_pkg::OUT_DEPTH));
    assign w_acc = i_valid && !o_stall;

    // reads: a and b in the accept cycle, c and c+1 in the following one
    assign w_c1_idx = {1'b0, r_q.src_c} + 33'd1;
    always_comb begin
        if (r_v1) begin
            w_raddr[0] = reg_addr(r_q.lane, r_q.src_c[7:0]);
            w_raddr[1] = reg_addr(r_q.lane, w_c1_idx[7:0]);
        end else begin
            w_raddr[0] = reg_addr(i_lane, i_src_a[7:0]);
            w_raddr[1] = reg_addr(i_lane, i_src_b[7:0]);
        end
        w_praddr[0] = pred_addr(i_lane, i_pred_src);
    end

    // write port: clearing pass, low word, then pending high word
    always_comb begin
        w_cur  = '0;
        w_pcur = '0;
        if (r_clr) begin
            w_cur.we    = int'(r_ccnt) < RDEPTH;
            w_cur.addr  = AW'(r_ccnt);
            w_pcur.we   = int'(r_ccnt) < PDEPTH;
            w_pcur.addr = PAW'(r_ccnt);
        end else begin
            if (r_vw && r_w.we_lo) begin
                w_cur.we   = 1'b1;
                w_cur.addr = r_w.a_lo;
                w_cur.data = w_res.lo;
            end else if (r_hp_we) begin
                w_cur.we   = 1'b1;
                w_cur.addr = r_hp_a;
                w_cur.data = r_hp_d;
            end
            w_pcur.we   = r_vw && r_w.we_p;
            w_pcur.addr = r_w.a_p;
            w_pcur.data = r_w.carry;
        end
    end

    gial_ram #(.WIDTH(32), .DEPTH(RDEPTH), .RD_PORTS(2), .AW(AW)) u_rf (
        .i_clk   (i_clk),
        .i_we    (w_cur.we),
        .i_waddr (w_cur.addr),
        .i_wdata (w_cur.data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    gial_ram #(.WIDTH(1), .DEPTH(PDEPTH), .RD_PORTS(1), .AW(PAW)) u_pf (
        .i_clk   (i_clk),
        .i_we    (w_pcur.we),
        .i_waddr (w_pcur.addr),
        .i_wdata (w_pcur.data),
        .i_raddr (w_praddr),
        .o_rdata (w_prdata)
    );

    // execute stage
    always_comb begin
        w_ia = r_x.kind[gial_pkg::KIND_A];
        w_ib = r_x.kind[gial_pkg::KIND_B];
        w_ic = r_x.kind[gial_pkg::KIND_C];
        w_m0 = r_x.modifier[gial_pkg::MOD_M0];
        w_m1 = r_x.modifier[gial_pkg::MOD_M1];
        w_rd1 = {1'b0, r_x.dest_reg} + 9'd1;

        w_ok_a   = reg_ok(r_x.lane, {1'b0, r_x.src_a});
        w_ok_b   = reg_ok(r_x.lane, {1'b0, r_x.src_b});
        w_ok_c   = reg_ok(r_x.lane, {1'b0, r_x.src_c});
        w_ok_c1  = reg_ok(r_x.lane, {1'b0, r_x.src_c} + 33'd1);
        w_ok_rd  = reg_ok(r_x.lane, {25'b0, r_x.dest_reg});
        w_ok_rd1 = reg_ok(r_x.lane, {24'b0, w_rd1});
        w_ok_ps  = lane_ok(r_x.lane) && (int'(r_x.pred_src) < PREDS);
        w_ok_pd  = lane_ok(r_x.lane) && (int'(r_x.pred_dest) < PREDS);

        w_a  = w_ia ? r_x.src_a :
               (w_ok_a ? fwd(reg_addr(r_x.lane, r_x.src_a[7:0]), r_da, w_cur, r_h1, r_h2)
                       : 32'd0);
        w_b  = w_ib ? r_x.src_b :
               (w_ok_b ? fwd(reg_addr(r_x.lane, r_x.src_b[7:0]), r_db, w_cur, r_h1, r_h2)
                       : 32'd0);
        w_c  = w_ic ? r_x.src_c :
               (w_ok_c ? fwd(reg_addr(r_x.lane, r_x.src_c[7:0]), w_rdata[0],
                             w_cur, r_h1, r_h2) : 32'd0);
        w_c1 = (w_ic || !w_m0 || !w_ok_c1) ? 32'd0 :
               fwd(reg_addr(r_x.lane, r_x.src_c[7:0] + 8'd1), w_rdata[1], w_cur, r_h1, r_h2);
        w_p  = w_ok_ps ? pfwd(pred_addr(r_x.lane, r_x.pred_src), r_pd, w_pcur, r_ph1, r_ph2)
                       : 1'b0;

        // three-input logic: one minterm per truth-table bit
        w_lop = '0;
        for (int i = 0; i < 8; i++) begin
            w_m = 3'(i);
            if (r_x.lut[i]) begin
                w_lop = w_lop | ((w_m[2] ? w_a : ~w_a) & (w_m[1] ? w_b : ~w_b)
                                 & (w_m[0] ? w_c : ~w_c));
            end
        end

        w_pair = {w_c, w_a};
        if (r_x.src_b >= 32'd64) begin
            w_shf = '0;
        end else if (w_m0) begin
            w_shf = w_pair << r_x.src_b[5:0];
        end else begin
            w_shf = w_pair >> r_x.src_b[5:0];
        end

        w_hsh   = 6'd32 - {1'b0, r_x.lut[4:0]};
        w_lea_v = w_m0 ? (w_pair >> w_hsh) : (w_pair << r_x.lut[4:0]);
        w_sum33 = w_lea_v[32:0] + {1'b0, w_b} + {32'b0, w_m1 && w_p};

        n_w       = '0;
        n_w.op    = r_x.op;
        n_w.m0    = w_m0;
        n_w.c64   = {w_c1, w_c};
        n_w.a_lo  = reg_addr(r_x.lane, r_x.dest_reg);
        n_w.a_hi  = reg_addr(r_x.lane, w_rd1[7:0]);
        n_w.a_p   = pred_addr(r_x.lane, r_x.pred_dest);
        n_w.we_lo = w_ok_rd;
        n_w.err   = !w_ok_rd || (!w_ia && !w_ok_a) || (!w_ic && !w_ok_c);
        unique case (r_x.op)
            gial_pkg::OP_MAD: begin
                n_w.we_hi = w_m0 && w_ok_rd1;
                n_w.err   = n_w.err || (!w_ib && !w_ok_b)
                            || (w_m0 && (!w_ok_rd1 || (!w_ic && !w_ok_c1)));
            end
            gial_pkg::OP_LOP: begin
                n_w.lo_x = w_lop;
                n_w.err  = n_w.err || (!w_ib && !w_ok_b);
            end
            gial_pkg::OP_SHF: begin
                n_w.lo_x = w_shf[31:0];
            end
            gial_pkg::OP_LEA: begin
                n_w.lo_x  = w_sum33[31:0];
                n_w.carry = w_sum33[32];
                n_w.we_p  = w_ok_pd;
                n_w.err   = n_w.err || (!w_ib && !w_ok_b) || !w_ok_pd || (w_m1 && !w_ok_ps);
            end
            default: begin
                n_w.lo_x = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    // write-back stage
    assign w_mad = r_prod + r_w.c64;
    always_comb begin
        w_res       = '0;
        w_res.carry = r_w.carry;
        w_res.err   = r_w.err;
        if (r_w.op == gial_pkg::OP_MAD) begin
            w_res.lo = w_mad[31:0];
            w_res.hi = r_w.m0 ? w_mad[63:32] : 32'd0;
        end else begin
            w_res.lo = r_w.lo_x;
        end
    end

    assign w_pop         = o_valid && !i_stall;
    assign o_valid       = r_ocnt != '0;
    assign o_result_low  = r_oq[r_rp].lo;
    assign o_result_high = r_oq[r_rp].hi;
    assign o_carry_out   = r_oq[r_rp].carry;
    assign o_index_error = r_oq[r_rp].err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= 1'b1;
            r_ccnt  <= '0;
            r_v1    <= 1'b0;
            r_vx    <= 1'b0;
            r_vw    <= 1'b0;
            r_hp_we <= 1'b0;
            r_h1    <= '0;
            r_h2    <= '0;
            r_ph1   <= '0;
            r_ph2   <= '0;
            r_wp    <= '0;
            r_rp    <= '0;
            r_ocnt  <= '0;
        end else begin
            if (r_clr) begin
                r_ccnt <= r_ccnt + 1'b1;
                if (int'(r_ccnt) == CLR_N - 1) begin
                    r_clr <= 1'b0;
                end
            end
            r_v1    <= w_acc;
            r_vx    <= r_v1;
            r_vw    <= r_vx;
            r_hp_we <= r_vw && r_w.we_hi;
            r_h1    <= w_cur;
            r_h2    <= r_h1;
            r_ph1   <= w_pcur;
            r_ph2   <= r_ph1;
            if (r_vw) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_ocnt <= r_ocnt + gial_pkg::OUT_CNT_W'(r_vw) - gial_pkg::OUT_CNT_W'(w_pop);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q <= w_in;
        end
        if (r_v1) begin
            r_x  <= r_q;
            r_da <= w_rdata[0];
            r_db <= w_rdata[1];
            r_pd <= w_prdata[0][0];
        end
        if (r_vx) begin
            r_w    <= n_w;
            r_prod <= w_prod;
        end
        if (r_vw) begin
            r_hp_a        <= r_w.a_hi;
            r_hp_d        <= w_res.hi;
            r_oq[r_wp]    <= w_res;
        end
    end

endmodule

[hdl/gial_ram.sv]
module gial_ram #(
    parameter int WIDTH    = 32,
    parameter int DEPTH    = 256,
    parameter int RD_PORTS = 2,
    parameter int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [AW-1:0]                      i_waddr,
    input  logic [WIDTH-1:0]                   i_wdata,
    input  logic [RD_PORTS-1:0][AW-1:0]        i_raddr,
    output logic [RD_PORTS-1:0][WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        for (int p = 0; p < RD_PORTS; p++) begin
            o_rdata[p] <= r_mem[i_raddr[p]];
        end
    end

endmodule

[hdl/gial_chk.sv]
module gial_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_result_low,
    input logic [31:0] o_result_high,
    input logic        o_carry_out,
    input logic        o_index_error
);

    // no result survives reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // clearing pass holds off input after reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> o_stall)
        else $error("input taken during clearing pass");

    // an accepted transaction holds the read ports while it reads c and c+1, stalling input
    a_two_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("transaction accepted in back-to-back cycles");

    // carry comes only from the address op, high word only from multiply-add
    a_carry_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_carry_out |-> o_result_high == 32'd0)
        else $error("carry and high word both set");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_low) && $stable(o_index_error))
        else $error("stalled result changed");

endmodule

bind gpu_integer_alu_lane gial_chk u_gial_chk (.*);

[verif/tb_gpu_integer_alu_lane.sv]
`timescale 1ns / 1ps

module tb_gpu_integer_alu_lane;

    localparam int NTHREADS = 32;
    localparam int NREGS    = 256;
    localparam int NPREDS   = 8;
    localparam int NRANDOM  = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_op;
    logic [4:0]  i_lane;
    logic [7:0]  i_dest_reg;
    logic [31:0] i_src_a;
    logic [31:0] i_src_b;
    logic [31:0] i_src_c;
    logic [2:0]  i_operand_kind;
    logic [7:0]  i_lut_or_shift;
    logic [1:0]  i_modifier;
    logic [2:0]  i_pred_dest;
    logic [2:0]  i_pred_src;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_result_low;
    logic [31:0] o_result_high;
    logic        o_carry_out;
    logic        o_index_error;

    gpu_integer_alu_lane uut (.*);

    gial_pkg::t_item   pending_instrs[$];
    gial_pkg::t_result expected_results[$];
    logic [31:0] lane_regs [NTHREADS*NREGS];
    logic        lane_preds[NTHREADS*NPREDS];
    bit          access_fault;
    int          mismatches;
    int          issued;
    int          send_idle_pct;
    int          recv_idle_pct;

    function automatic void queue_instr(gial_pkg::t_item it);
        pending_instrs.insert(pending_instrs.size(), it);
    endfunction

    function automatic logic [31:0] read_reg(logic [4:0] lane, logic [32:0] idx);
        if (idx >= NREGS) begin
            access_fault = 1'b1;
            return '0;
        end
        return lane_regs[lane*NREGS + idx];
    endfunction

    function automatic void write_reg(logic [4:0] lane, logic [32:0] idx, logic [31:0] v);
        if (idx >= NREGS) access_fault = 1'b1;
        else lane_regs[lane*NREGS + idx] = v;
    endfunction

    function automatic logic [31:0] fetch(logic [4:0] lane, logic [31:0] v, logic imm);
        return imm ? v : read_reg(lane, {1'b0, v});
    endfunction

    // Execute one instruction against the shadow register state.
    function automatic gial_pkg::t_result alu_execute(gial_pkg::t_item it);
        gial_pkg::t_result r;
        logic [63:0] c64, v;
        logic [31:0] a, b, c;
        logic        m0, m1;
        r = '0;
        access_fault = 1'b0;
        m0 = it.modifier[gial_pkg::MOD_M0];
        m1 = it.modifier[gial_pkg::MOD_M1];
        case (it.op)
            gial_pkg::OP_MAD: begin
                if (it.kind[gial_pkg::KIND_C]) begin
                    c64 = {32'd0, it.src_c};
                end else begin
                    c64 = {32'd0, read_reg(it.lane, {1'b0, it.src_c})};
                    if (m0) c64[63:32] = read_reg(it.lane, {1'b0, it.src_c} + 33'd1);
                end
                b = fetch(it.lane, it.src_b, it.kind[gial_pkg::KIND_B]);
                a = fetch(it.lane, it.src_a, it.kind[gial_pkg::KIND_A]);
                v = {32'd0, a} * {32'd0, b} + c64;
                r.lo = v[31:0];
                write_reg(it.lane, {25'd0, it.dest_reg}, r.lo);
                if (m0) begin
                    r.hi = v[63:32];
                    write_reg(it.lane, {25'd0, it.dest_reg} + 33'd1, r.hi);
                end
            end
            gial_pkg::OP_LOP: begin
                c = fetch(it.lane, it.src_c, it.kind[gial_pkg::KIND_C]);
                b = fetch(it.lane, it.src_b, it.kind[gial_pkg::KIND_B]);
                a = fetch(it.lane, it.src_a, it.kind[gial_pkg::KIND_A]);
                for (int k = 0; k < 32; k++) r.lo[k] = it.lut[{a[k], b[k], c[k]}];
                write_reg(it.lane, {25'd0, it.dest_reg}, r.lo);
            end
            gial_pkg::OP_SHF: begin
                a = fetch(it.lane, it.src_a, it.kind[gial_pkg::KIND_A]);
                c = fetch(it.lane, it.src_c, it.kind[gial_pkg::KIND_C]);
                v = {c, a};
                if (it.src_b >= 64) v = '0;
                else v = m0 ? (v << it.src_b) : (v >> it.src_b);
                r.lo = v[31:0];
                write_reg(it.lane, {25'd0, it.dest_reg}, r.lo);
            end
            default: begin
                c = fetch(it.lane, it.src_c, it.kind[gial_pkg::KIND_C]);
                b = fetch(it.lane, it.src_b, it.kind[gial_pkg::KIND_B]);
                a = fetch(it.lane, it.src_a, it.kind[gial_pkg::KIND_A]);
                v = {c, a};
                v = m0 ? (v >> (32 - it.lut[4:0])) : (v << it.lut[4:0]);
                v = v + {32'd0, b};
                if (m1) v = v + {63'd0, lane_preds[it.lane*NPREDS + it.pred_src]};
                r.carry = v[32];
                r.lo = v[31:0];
                lane_preds[it.lane*NPREDS + it.pred_dest] = r.carry;
                write_reg(it.lane, {25'd0, it.dest_reg}, r.lo);
            end
        endcase
        r.err = access_fault;
        return r;
    endfunction

    function automatic gial_pkg::t_item mk(gial_pkg::t_op op, logic [4:0] lane, logic [7:0] rd,
                                           logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                           logic [2:0] kind, logic [7:0] lut, logic [1:0] md,
                                           logic [2:0] pd, logic [2:0] ps);
        gial_pkg::t_item it;
        it.op = op; it.lane = lane; it.dest_reg = rd;
        it.src_a = a; it.src_b = b; it.src_c = c;
        it.kind = kind; it.lut = lut; it.modifier = md;
        it.pred_dest = pd; it.pred_src = ps;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'hffff_ffff;
            1: return 32'd0;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly low register numbers so writes are read back; a few out of range.
    function automatic logic [31:0] rand_source(logic imm);
        if (imm) return rand_word();
        case ($urandom_range(0, 19))
            0: return 32'd255;
            1: return 32'd256;
            2: return $urandom;
            default: return $urandom_range(0, 15);
        endcase
    endfunction

    function automatic gial_pkg::t_item rand_instr();
        gial_pkg::t_item it;
        it.op = gial_pkg::t_op'($urandom_range(0, 3));
        it.lane = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 1));
        it.dest_reg = ($urandom_range(0, 15) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        it.kind = 3'($urandom);
        it.src_a = rand_source(it.kind[gial_pkg::KIND_A]);
        it.src_b = rand_source(it.kind[gial_pkg::KIND_B]);
        it.src_c = rand_source(it.kind[gial_pkg::KIND_C]);
        if (it.op == gial_pkg::OP_SHF)
            it.src_b = ($urandom_range(0, 7) == 0) ? rand_word() : $urandom_range(0, 70);
        it.lut = 8'($urandom);
        it.modifier = 2'($urandom);
        it.pred_dest = 3'($urandom);
        it.pred_src = 3'($urandom);
        return it;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        for (int k = 0; k < NTHREADS*NREGS; k++) lane_regs[k] = '0;
        for (int k = 0; k < NTHREADS*NPREDS; k++) lane_preds[k] = 1'b0;
        // directed: extremes, every op, wide corners, shift edges, carry chains
        queue_instr(mk(gial_pkg::OP_MAD, 0, 1, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                       3'b111, 0, 2'b01, 0, 0));
        queue_instr(mk(gial_pkg::OP_MAD, 0, 3, 1, 2, 1, 3'b000, 0, 2'b01, 0, 0));
        queue_instr(mk(gial_pkg::OP_MAD, 0, 255, 32'h1234, 32'h5678, 7, 3'b111, 0, 2'b01,
                       0, 0));
        queue_instr(mk(gial_pkg::OP_MAD, 31, 4, 5, 6, 255, 3'b110, 0, 2'b01, 0, 0));
        queue_instr(mk(gial_pkg::OP_MAD, 0, 5, 1, 2, 3, 3'b000, 0, 2'b10, 0, 0));
        queue_instr(mk(gial_pkg::OP_LOP, 0, 6, 1, 2, 3, 3'b000, 8'h00, 0, 0, 0));
        queue_instr(mk(gial_pkg::OP_LOP, 0, 7, 1, 2, 3, 3'b000, 8'hff, 0, 0, 0));
        queue_instr(mk(gial_pkg::OP_LOP, 0, 8, 32'hf0f0f0f0, 32'hcccccccc, 32'haaaaaaaa,
                       3'b111, 8'he8, 0, 0, 0));
        queue_instr(mk(gial_pkg::OP_LOP, 0, 9, 256, 32'hffffffff, 1, 3'b000, 8'h80, 0, 0, 0));
        queue_instr(mk(gial_pkg::OP_SHF, 0, 10, 32'h89abcdef, 0, 32'h01234567, 3'b101, 0,
                       2'b01, 0, 0));
        queue_instr(mk(gial_pkg::OP_SHF, 0, 11, 32'h89abcdef, 31, 32'h01234567, 3'b101, 0,
                       2'b00, 0, 0));
        queue_instr(mk(gial_pkg::OP_SHF, 0, 12, 32'h89abcdef, 32, 32'h01234567, 3'b101, 0,
                       2'b11, 0, 0));
        queue_instr(mk(gial_pkg::OP_SHF, 0, 13, 32'h89abcdef, 63, 32'h01234567, 3'b101, 0,
                       2'b00, 0, 0));
        queue_instr(mk(gial_pkg::OP_SHF, 0, 14, 32'h89abcdef, 64, 32'h01234567, 3'b101, 0,
                       2'b01, 0, 0));
        queue_instr(mk(gial_pkg::OP_SHF, 0, 15, 1, 32'hffffffff, 2, 3'b000, 0, 2'b00, 0, 0));
        queue_instr(mk(gial_pkg::OP_LEA, 0, 16, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                       3'b111, 8'h1f, 2'b00, 7, 0));
        queue_instr(mk(gial_pkg::OP_LEA, 0, 17, 32'hffffffff, 1, 0, 3'b111, 8'h00, 2'b10,
                       3, 7));
        queue_instr(mk(gial_pkg::OP_LEA, 0, 18, 32'h80000000, 32'hffffffff, 32'h1,
                       3'b111, 8'he0, 2'b11, 0, 3));
        queue_instr(mk(gial_pkg::OP_LEA, 0, 19, 32'h80000000, 0, 32'hffffffff, 3'b111,
                       8'h1f, 2'b01, 1, 0));
        queue_instr(mk(gial_pkg::OP_LEA, 31, 20, 32'hffffffff, 1, 0, 3'b000, 8'h04, 2'b10,
                       2, 1));
        for (int k = 0; k < NRANDOM; k++) queue_instr(rand_instr());
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                expected_results.insert(expected_results.size(),
                    alu_execute(gial_pkg::t_item'({i_op, i_lane, i_dest_reg,
                    i_src_a, i_src_b, i_src_c, i_operand_kind, i_lut_or_shift, i_modifier,
                    i_pred_dest, i_pred_src})));
                issued <= issued + 1;
            end
            if (pending_instrs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                gial_pkg::t_item it;
                it = pending_instrs.pop_front();
                i_valid        <= 1'b1;
                i_op           <= it.op;
                i_lane         <= it.lane;
                i_dest_reg     <= it.dest_reg;
                i_src_a        <= it.src_a;
                i_src_b        <= it.src_b;
                i_src_c        <= it.src_c;
                i_operand_kind <= it.kind;
                i_lut_or_shift <= it.lut;
                i_modifier     <= it.modifier;
                i_pred_dest    <= it.pred_dest;
                i_pred_src     <= it.pred_src;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure and idle phases
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        if (issued < 220) begin
            send_idle_pct <= 17;
            recv_idle_pct <= 57;
        end else if (issued < 440) begin
            send_idle_pct <= 57;
            recv_idle_pct <= 17;
        end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                if (mismatches < 10) $display("unexpected transaction: lo=%h hi=%h c=%b e=%b",
                    o_result_low, o_result_high, o_carry_out, o_index_error);
                mismatches <= mismatches + 1;
            end else begin
                gial_pkg::t_result exp_r;
                exp_r = expected_results.pop_front();
                if (o_result_low !== exp_r.lo || o_result_high !== exp_r.hi ||
                    o_carry_out !== exp_r.carry || o_index_error !== exp_r.err) begin
                    if (mismatches < 10)
                        $display("mismatch: exp lo=%h hi=%h c=%b e=%b got lo=%h hi=%h c=%b e=%b",
                            exp_r.lo, exp_r.hi, exp_r.carry, exp_r.err, o_result_low,
                            o_result_high, o_carry_out, o_index_error);
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    initial begin
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_op = '0; i_lane = '0; i_dest_reg = '0;
        i_src_a = '0; i_src_b = '0; i_src_c = '0;
        i_operand_kind = '0; i_lut_or_shift = '0; i_modifier = '0;
        i_pred_dest = '0; i_pred_src = '0;
        mismatches = 0;
        issued = 0;
        send_idle_pct = 17;
        recv_idle_pct = 57;
        @(posedge i_rst_n);
        do @(posedge i_clk);
        while (pending_instrs.size() != 0 || i_valid || expected_results.size() != 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
hdl/gial_pkg.sv
hdl/gial_ram.sv
hdl/gpu_integer_alu_lane.sv
hdl/gial_chk.sv
verif/tb_gpu_integer_alu_lane.sv
